// ----- hw/rtl/bamc_pkg.sv -----
// ----------------------------------------------------------------------------
// bamc_pkg
// Shared types, constants and the base decode table of the BAM chunker.
// ----------------------------------------------------------------------------
`default_nettype none

package bamc_pkg;

  // Width kept of the record's sequence length field (16 to 32).
  localparam int SEQ_LEN_BITS = 32;
  // Signed width of the count of bases still to come in the record.
  localparam int REM_W        = SEQ_LEN_BITS + 1;

  localparam logic [15:0] CHUNK_LEN_RESET = 16'd36;

  // Byte offsets within a record at which header fields complete.
  localparam logic [31:0] OFF_BLOCK_SIZE = 32'd3;
  localparam logic [31:0] OFF_NAME_LEN   = 32'd15;
  localparam logic [31:0] OFF_CIGAR_CNT  = 32'd19;
  localparam logic [31:0] OFF_SEQ_LEN    = 32'd23;
  localparam logic [31:0] HDR_BYTES      = 32'd36;

  typedef struct packed {
    logic [7:0] base_char;
    logic       chunk_first;
    logic       chunk_last;
    logic       last;
  } result_t;

  // Results caused by one input byte, in delivery order.
  typedef struct packed {
    logic [1:0] count;
    result_t    first_res;
    result_t    second_res;
  } pair_t;

  // Decodes a packed 4-bit base code to its ASCII letter.
  function automatic logic [7:0] decode_base(input logic [3:0] code);
    logic [7:0] ch;
    case (code)
      4'd0:    ch = 8'h3D; // '='
      4'd1:    ch = 8'h41; // 'A'
      4'd2:    ch = 8'h43; // 'C'
      4'd3:    ch = 8'h4D; // 'M'
      4'd4:    ch = 8'h47; // 'G'
      4'd5:    ch = 8'h52; // 'R'
      4'd6:    ch = 8'h53; // 'S'
      4'd7:    ch = 8'h56; // 'V'
      4'd8:    ch = 8'h54; // 'T'
      4'd9:    ch = 8'h57; // 'W'
      4'd10:   ch = 8'h59; // 'Y'
      4'd11:   ch = 8'h48; // 'H'
      4'd12:   ch = 8'h4B; // 'K'
      4'd13:   ch = 8'h44; // 'D'
      4'd14:   ch = 8'h42; // 'B'
      default: ch = 8'h4E; // 'N'
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/bamc_parser.sv -----
// ----------------------------------------------------------------------------
// bamc_parser
// Input byte register, record walker and base decode for one byte per beat.
// ----------------------------------------------------------------------------
`default_nettype none

module bamc_parser (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            s_axis_tvalid,
  output logic                 s_axis_tready,
  input  wire logic [7:0]      s_axis_tdata,   // [7:0] data_byte
  input  wire logic [15:0]     chunk_len,
  output bamc_pkg::pair_t      pair,
  output logic                 pair_valid,
  input  wire logic            pair_ready
);

  localparam int CL_PAD = bamc_pkg::REM_W - 16;

  logic                                in_valid;
  logic [7:0]                          in_byte;

  logic [31:0]                         record_offset;
  logic [31:0]                         word_assembly;
  logic [31:0]                         record_size;
  logic [7:0]                          name_length;
  logic [15:0]                         cigar_count;
  logic [bamc_pkg::SEQ_LEN_BITS-1:0]   sequence_length;
  logic signed [bamc_pkg::REM_W-1:0]   remaining;
  logic [15:0]                         chunk_position;

  // Derived bounds, registered from the header fields.
  logic [18:0]                         seq_start;
  logic [32:0]                         seq_end;
  logic [31:0]                         end_m1;

  logic                                take;
  logic [31:0]                         word_next;
  logic                                in_window;
  logic                                rec_end;
  logic signed [bamc_pkg::REM_W-1:0]   rem_b;
  logic signed [bamc_pkg::REM_W-1:0]   cl_s;
  logic                                cl_zero;
  logic                                a_emit, a_close;
  logic                                b_emit, b_close;
  logic [15:0]                         cp_mid;
  logic [15:0]                         chunk_position_next;
  logic [32:0]                         end_sum;
  logic [bamc_pkg::SEQ_LEN_BITS:0]     seq_bytes;
  bamc_pkg::result_t                   res_a, res_b;

  assign take          = in_valid && pair_ready;
  assign s_axis_tready = !in_valid || pair_ready;
  assign pair_valid    = in_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte <= s_axis_tdata;
    end
  end

  assign end_sum   = {1'b0, record_size} + 33'd3;
  assign seq_bytes = ({1'b0, sequence_length} + 1'b1) >> 1;

  always_ff @(posedge clk) begin
    seq_start <= 19'd36 + {11'd0, name_length} + {1'b0, cigar_count, 2'b00};
    seq_end   <= {14'd0, seq_start} + 33'(seq_bytes);
    end_m1    <= end_sum[32] ? 32'hFFFF_FFFF : end_sum[31:0];
  end

  assign word_next = {in_byte, word_assembly[31:8]};
  assign in_window = (record_offset >= bamc_pkg::HDR_BYTES) &&
                     (record_offset >= {13'd0, seq_start}) &&
                     ({1'b0, record_offset} < seq_end);
  assign rec_end   = (record_offset >= bamc_pkg::HDR_BYTES - 32'd1) &&
                     (record_offset >= end_m1);

  // Chunk decisions for the high nibble base, then the low nibble base.
  assign cl_s    = $signed({{CL_PAD{1'b0}}, chunk_len});
  assign cl_zero = (chunk_len == 16'd0);
  assign rem_b   = remaining - 2'sd1;

  always_comb begin
    a_emit  = in_window && !cl_zero && (remaining > 0) &&
              ((chunk_position != 16'd0) || !(remaining < cl_s));
    a_close = ({1'b0, chunk_position} + 17'd1) >= {1'b0, chunk_len};
    if (a_emit) begin
      cp_mid = a_close ? 16'd0 : chunk_position + 16'd1;
    end else begin
      cp_mid = chunk_position;
    end
    b_emit  = in_window && !cl_zero && (rem_b > 0) &&
              ((cp_mid != 16'd0) || !(rem_b < cl_s));
    b_close = ({1'b0, cp_mid} + 17'd1) >= {1'b0, chunk_len};
    if (b_emit) begin
      chunk_position_next = b_close ? 16'd0 : cp_mid + 16'd1;
    end else begin
      chunk_position_next = cp_mid;
    end
  end

  always_comb begin
    res_a.base_char   = bamc_pkg::decode_base(in_byte[7:4]);
    res_a.chunk_first = (chunk_position == 16'd0);
    res_a.chunk_last  = a_close;
    res_a.last        = !b_emit;
    res_b.base_char   = bamc_pkg::decode_base(in_byte[3:0]);
    res_b.chunk_first = (cp_mid == 16'd0);
    res_b.chunk_last  = b_close;
    res_b.last        = 1'b1;
    pair.second_res   = res_b;
    if (a_emit) begin
      pair.first_res = res_a;
    end else begin
      pair.first_res = res_b;
    end
    pair.count = {1'b0, a_emit} + {1'b0, b_emit};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      record_offset   <= '0;
      word_assembly   <= '0;
      record_size     <= '0;
      name_length     <= '0;
      cigar_count     <= '0;
      sequence_length <= '0;
      remaining       <= '0;
      chunk_position  <= '0;
    end else if (take) begin
      word_assembly <= word_next;
      if (record_offset == bamc_pkg::OFF_BLOCK_SIZE) begin
        record_size <= word_next;
      end
      if (record_offset == bamc_pkg::OFF_NAME_LEN) begin
        name_length <= word_next[7:0];
      end
      if (record_offset == bamc_pkg::OFF_CIGAR_CNT) begin
        cigar_count <= word_next[15:0];
      end
      if (record_offset == bamc_pkg::OFF_SEQ_LEN) begin
        sequence_length <= word_next[bamc_pkg::SEQ_LEN_BITS-1:0];
        remaining       <= $signed({1'b0, word_next[bamc_pkg::SEQ_LEN_BITS-1:0]});
      end else if (in_window) begin
        remaining <= remaining - 3'sd2;
      end
      if (rec_end) begin
        record_offset  <= '0;
        chunk_position <= '0;
      end else begin
        record_offset  <= record_offset + 32'd1;
        chunk_position <= chunk_position_next;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/bamc_out_buf.sv -----
// ----------------------------------------------------------------------------
// bamc_out_buf
// Two-entry result register that hands the bases of one byte out one per beat.
// ----------------------------------------------------------------------------
`default_nettype none

module bamc_out_buf (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire bamc_pkg::pair_t   pair,
  input  wire logic              pair_valid,
  output logic                   pair_ready,
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic [7:0]             m_axis_tdata,  // [7:0] base_char
  output logic [1:0]             m_axis_tuser,  // [0] chunk_first, [1] chunk_last
  output logic                   m_axis_tlast   // last
);

  bamc_pkg::result_t slot0, slot1;
  logic [1:0]        count;
  logic              pop;
  logic              load;

  assign m_axis_tvalid = (count != 2'd0);
  assign pop           = m_axis_tvalid && m_axis_tready;
  assign pair_ready    = (count == 2'd0) || ((count == 2'd1) && pop);
  assign load          = pair_valid && pair_ready && (pair.count != 2'd0);

  assign m_axis_tdata  = slot0.base_char;
  assign m_axis_tuser  = {slot0.chunk_last, slot0.chunk_first};
  assign m_axis_tlast  = slot0.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (load) begin
      count <= pair.count;
    end else if (pop) begin
      count <= count - 2'd1;
    end
    if (load) begin
      slot0 <= pair.first_res;
      slot1 <= pair.second_res;
    end else if (pop) begin
      slot0 <= slot1;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/bam_record_sequence_chunker_core.sv -----
// ----------------------------------------------------------------------------
// bam_record_sequence_chunker_core
// Parses a decompressed BAM record stream and emits bases in whole chunks.
// ----------------------------------------------------------------------------
// The slave stream takes one byte of decompressed BAM records per beat, the
// records back to back. The master stream delivers one ASCII base per beat,
// with tuser[0] marking the first base of a chunk, tuser[1] the base that
// closes it, and tlast the final base caused by one input byte. Only complete
// chunks of chunk_len bases leave; any short tail of a record is dropped.
// The configuration channel (cfg_valid/cfg_ready/cfg_data) writes chunk_len;
// it is always ready and should be written only while the block is idle.
// An input byte passes through the input byte register and then the two-entry
// output register on its way to the master side. A byte that yields no base
// never enters the output register; a sequence byte yields up to two bases,
// which leave one per beat, and the next byte is taken only once the last of
// them is leaving. When the receiver stalls, the output register holds its
// bases and the input byte register fills, after which tready on the slave side
// drops. Reset clears the record walker to the start of a record, closes any
// open chunk, empties both registers and sets chunk_len to 36.
// ----------------------------------------------------------------------------
`default_nettype none

module bam_record_sequence_chunker_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // [7:0] base_char
  output logic [1:0]       m_axis_tuser,   // [0] chunk_first, [1] chunk_last
  output logic             m_axis_tlast,   // last
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data        // [15:0] chunk_len
);

  logic [15:0]      chunk_len;
  bamc_pkg::pair_t  pair;
  logic             pair_valid;
  logic             pair_ready;

  // The register write always completes in the beat it is offered.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_len <= bamc_pkg::CHUNK_LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      chunk_len <= cfg_data;
    end
  end

  // Byte register, header field capture and base decode.
  bamc_parser u_parser (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .chunk_len     (chunk_len),
    .pair          (pair),
    .pair_valid    (pair_valid),
    .pair_ready    (pair_ready)
  );

  // Result register that serialises the one or two bases of a byte.
  bamc_out_buf u_out_buf (
    .clk           (clk),
    .rst           (rst),
    .pair          (pair),
    .pair_valid    (pair_valid),
    .pair_ready    (pair_ready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

`default_nettype wire
